FILE: rtl/c8ic_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes for the CHIP-8 instruction core.
// No dependencies; c8ic_alu and the top level refer to this package by scoped names.
package c8ic_pkg;

  localparam int MEMORY_BYTES  = 4096;
  localparam int MEM_AW        = $clog2(MEMORY_BYTES);
  localparam int STACK_DEPTH   = 16;
  localparam int STACK_AW      = $clog2(STACK_DEPTH);
  localparam int LEVEL_W       = $clog2(STACK_DEPTH + 1);
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int ROW_AW        = $clog2(SCREEN_HEIGHT);
  localparam int NUM_REGS      = 16;
  localparam int REG_AW        = $clog2(NUM_REGS);

  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_EXEC  = 3'd1;
  localparam logic [2:0] CMD_TICK  = 3'd2;
  localparam logic [2:0] CMD_KEY   = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_ROW   = 3'd5;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_UNSUP     = 3'd1;
  localparam logic [2:0] STAT_RET_EMPTY = 3'd2;
  localparam logic [2:0] STAT_STK_FULL  = 3'd3;
  localparam logic [2:0] STAT_WAIT_KEY  = 3'd4;

  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_WAIT = 2'd1;
  localparam logic [1:0] PHASE_GOT  = 2'd2;

  localparam logic [2:0] REG_SHIFT_VY  = 3'd0;
  localparam logic [2:0] REG_BLK_ADV   = 3'd1;
  localparam logic [2:0] REG_OFS_VX    = 3'd2;
  localparam logic [2:0] REG_FONT_BASE = 3'd3;
  localparam logic [2:0] REG_PROG_STRT = 3'd4;

  localparam logic [11:0] FONT_BASE_RST  = 12'd80;
  localparam logic [11:0] PROG_START_RST = 12'd512;

  localparam logic [11:0] OPC_CLS = 12'h0E0;
  localparam logic [11:0] OPC_RET = 12'h0EE;
  localparam logic [7:0]  OPC_SKP  = 8'h9E;
  localparam logic [7:0]  OPC_SKNP = 8'hA1;
  localparam logic [7:0]  OPF_GET_DLY = 8'h07;
  localparam logic [7:0]  OPF_WAITKEY = 8'h0A;
  localparam logic [7:0]  OPF_SET_DLY = 8'h15;
  localparam logic [7:0]  OPF_SET_SND = 8'h18;
  localparam logic [7:0]  OPF_ADD_I   = 8'h1E;
  localparam logic [7:0]  OPF_FONT    = 8'h29;
  localparam logic [7:0]  OPF_BCD     = 8'h33;
  localparam logic [7:0]  OPF_STORE   = 8'h55;
  localparam logic [7:0]  OPF_LOAD    = 8'h65;

  typedef enum logic [3:0] {
    ALU_ADD8,
    ALU_SUB8,
    ALU_OR,
    ALU_AND,
    ALU_XOR,
    ALU_SHR,
    ALU_SHL,
    ALU_ADD12
  } alu_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CMD, S_RDB, S_RDROW,
    S_F1, S_F2, S_F3, S_F4, S_F5, S_EXEC,
    S_RET, S_SKIP, S_WRX, S_FONT,
    S_BCDH, S_BCDT, S_BCDW0, S_BCDW1, S_BCDW2,
    S_STRD, S_STWR, S_LDRD, S_LDWR, S_ADV,
    S_DRRD, S_DRWR, S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] address;
    logic [7:0]  write_data;
    logic [3:0]  key_number;
    logic        key_pressed;
    logic [7:0]  random_byte;
    logic [4:0]  display_row;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] program_counter;
    logic [7:0]  read_byte;
    logic [63:0] row_pixels;
  } out_item_t;

endpackage

FILE: rtl/c8ic_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module c8ic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/c8ic_alu.sv
`timescale 1ns / 1ps
// Shared arithmetic, logic and shift unit used by the instruction sequencer.
// Depends on c8ic_pkg.
module c8ic_alu (
  input  c8ic_pkg::alu_op_t op,
  input  logic [11:0]       a,
  input  logic [11:0]       b,
  output logic [11:0]       y,
  output logic              c,
  output logic              z
);

  logic [8:0]  s9;
  logic [12:0] s13;

  always_comb begin
    s9  = {1'b0, a[7:0]} + {1'b0, b[7:0]};
    s13 = {1'b0, a} + {1'b0, b};
    y   = '0;
    c   = 1'b0;
    unique case (op)
      c8ic_pkg::ALU_ADD8: begin
        y = {4'd0, s9[7:0]};
        c = s9[8];
      end
      c8ic_pkg::ALU_SUB8: begin
        y = {4'd0, a[7:0] - b[7:0]};
        c = (a[7:0] >= b[7:0]);
      end
      c8ic_pkg::ALU_OR:  y = {4'd0, a[7:0] | b[7:0]};
      c8ic_pkg::ALU_AND: y = {4'd0, a[7:0] & b[7:0]};
      c8ic_pkg::ALU_XOR: y = {4'd0, a[7:0] ^ b[7:0]};
      c8ic_pkg::ALU_SHR: begin
        y = {5'd0, a[7:1]};
        c = a[0];
      end
      c8ic_pkg::ALU_SHL: begin
        y = {4'd0, a[6:0], 1'b0};
        c = a[7];
      end
      c8ic_pkg::ALU_ADD12: begin
        y = s13[11:0];
        c = s13[12];
      end
      default: begin
        y = '0;
        c = 1'b0;
      end
    endcase
    z = (y == 12'd0);
  end

endmodule

FILE: rtl/chip8_instruction_core.sv
`timescale 1ns / 1ps
// Top level of the CHIP-8 instruction core: sequencer, state, memories, config port.
// Depends on c8ic_pkg, c8ic_ram and c8ic_alu.
//
// One command is taken at a time over a valid/ready channel and gives one result
// transaction. Memory write, timer tick and key events act in S_CMD; reads pass
// through S_RDB or S_RDROW as well. An instruction fetches the opcode and then Vx,
// Vy, V0 through the single read port of the program memory and register file,
// then executes. Sprite draw does a read-modify-write of the display memory per
// row (up to 15 rows), block store/load handles one register at a time, and BCD
// does repeated subtraction in the shared ALU followed by three memory writes. The
// next command is accepted while a result still waits on out_ready. No clearing
// pass is needed after reset.
module chip8_instruction_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  c8ic_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output c8ic_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int MAW = c8ic_pkg::MEM_AW;
  localparam int SAW = c8ic_pkg::STACK_AW;
  localparam int LVW = c8ic_pkg::LEVEL_W;
  localparam int RAW = c8ic_pkg::ROW_AW;
  localparam int GAW = c8ic_pkg::REG_AW;
  localparam int SW  = c8ic_pkg::SCREEN_WIDTH;
  localparam int NR  = c8ic_pkg::NUM_REGS;
  localparam int SH  = c8ic_pkg::SCREEN_HEIGHT;

  c8ic_pkg::state_t   state_r, state_nxt;
  c8ic_pkg::in_item_t cmd_r, cmd_nxt;

  logic [7:0]  hi_r, hi_nxt, lo_r, lo_nxt;
  logic [7:0]  vx_r, vx_nxt, vy_r, vy_nxt, v0_r, v0_nxt;
  logic [11:0] pc_r, pc_nxt, idx_r, idx_nxt, res_r, res_nxt;
  logic [LVW-1:0] lvl_r, lvl_nxt;
  logic [7:0]  dly_r, dly_nxt;
  logic [15:0] keys_r, keys_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  capk_r, capk_nxt;
  logic [3:0]  cnt_r, cnt_nxt, hund_r, hund_nxt, tens_r, tens_nxt;
  logic        col_r, col_nxt;
  logic        shift_vy_r, shift_vy_nxt, blk_adv_r, blk_adv_nxt, ofs_vx_r, ofs_vx_nxt;
  logic [11:0] font_base_r, font_base_nxt, prog_start_r, prog_start_nxt;
  logic [NR-1:0] rf_vld_r, rf_vld_nxt;
  logic [SH-1:0] dp_vld_r, dp_vld_nxt;
  logic        rf_rv_r, rf_rv_nxt, dp_rv_r, dp_rv_nxt;
  logic [2:0]  rs_status_r, rs_status_nxt;
  logic [7:0]  rs_rbyte_r, rs_rbyte_nxt;
  logic [63:0] rs_row_r, rs_row_nxt;
  logic        out_valid_r, out_valid_nxt;
  c8ic_pkg::out_item_t out_data_r, out_data_nxt;

  logic           pm_we;
  logic [MAW-1:0] pm_waddr, pm_raddr;
  logic [7:0]     pm_wdata, pm_rdata;
  logic           rf_we;
  logic [GAW-1:0] rf_waddr, rf_raddr;
  logic [7:0]     rf_wdata, rf_rdata, rf_val;
  logic           dp_we;
  logic [RAW-1:0] dp_waddr, dp_raddr;
  logic [SW-1:0]  dp_wdata, dp_rdata, dp_val;
  logic           stk_we;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  logic [11:0]    stk_wdata, stk_rdata;

  c8ic_pkg::alu_op_t alu_op;
  logic [11:0] alu_a, alu_b, alu_y;
  logic        alu_c, alu_z;

  logic [3:0]  x;
  logic [11:0] nnn;
  logic [5:0]  py;
  logic [7:0]  rev;
  logic [SW-1:0] mask;
  logic        pressed;
  logic        cfg_wr;
  logic [LVW-1:0] lvl_dec;

  c8ic_ram #(.WIDTH(8), .DEPTH(c8ic_pkg::MEMORY_BYTES)) u_pmem (
    .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .raddr(pm_raddr), .rdata(pm_rdata)
  );

  c8ic_ram #(.WIDTH(8), .DEPTH(NR)) u_regs (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata)
  );

  c8ic_ram #(.WIDTH(SW), .DEPTH(SH)) u_disp (
    .clk(clk), .we(dp_we), .waddr(dp_waddr), .wdata(dp_wdata),
    .raddr(dp_raddr), .rdata(dp_rdata)
  );

  c8ic_ram #(.WIDTH(12), .DEPTH(c8ic_pkg::STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  c8ic_alu u_alu (
    .op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y), .c(alu_c), .z(alu_z)
  );

  assign in_ready  = (state_r == c8ic_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite;

  assign x       = hi_r[3:0];
  assign nnn     = {hi_r[3:0], lo_r};
  assign rf_val  = rf_rv_r ? rf_rdata : 8'd0;
  assign dp_val  = dp_rv_r ? dp_rdata : '0;
  assign py      = {1'b0, vy_r[4:0]} + {2'd0, cnt_r};
  assign rev     = {pm_rdata[0], pm_rdata[1], pm_rdata[2], pm_rdata[3],
                    pm_rdata[4], pm_rdata[5], pm_rdata[6], pm_rdata[7]};
  assign mask    = {{(SW - 8){1'b0}}, rev} << vx_r[5:0];
  assign pressed = (vx_r[7:4] == 4'd0) & keys_r[vx_r[3:0]];
  assign lvl_dec = lvl_r - LVW'(1);

  always_comb begin
    unique case (paddr[4:2])
      c8ic_pkg::REG_SHIFT_VY:  prdata = {31'd0, shift_vy_r};
      c8ic_pkg::REG_BLK_ADV:   prdata = {31'd0, blk_adv_r};
      c8ic_pkg::REG_OFS_VX:    prdata = {31'd0, ofs_vx_r};
      c8ic_pkg::REG_FONT_BASE: prdata = {20'd0, font_base_r};
      c8ic_pkg::REG_PROG_STRT: prdata = {20'd0, prog_start_r};
      default:                 prdata = 32'd0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    hi_nxt = hi_r; lo_nxt = lo_r;
    vx_nxt = vx_r; vy_nxt = vy_r; v0_nxt = v0_r;
    pc_nxt = pc_r; idx_nxt = idx_r; res_nxt = res_r;
    lvl_nxt = lvl_r; dly_nxt = dly_r; keys_nxt = keys_r;
    phase_nxt = phase_r; capk_nxt = capk_r;
    cnt_nxt = cnt_r; hund_nxt = hund_r; tens_nxt = tens_r; col_nxt = col_r;
    shift_vy_nxt = shift_vy_r; blk_adv_nxt = blk_adv_r; ofs_vx_nxt = ofs_vx_r;
    font_base_nxt = font_base_r; prog_start_nxt = prog_start_r;
    rf_vld_nxt = rf_vld_r; dp_vld_nxt = dp_vld_r;
    rs_status_nxt = rs_status_r; rs_rbyte_nxt = rs_rbyte_r; rs_row_nxt = rs_row_r;
    out_valid_nxt = out_valid_r; out_data_nxt = out_data_r;

    pm_we = 1'b0; pm_waddr = '0; pm_wdata = '0; pm_raddr = '0;
    rf_we = 1'b0; rf_waddr = '0; rf_wdata = '0; rf_raddr = '0;
    dp_we = 1'b0; dp_waddr = '0; dp_wdata = '0; dp_raddr = '0;
    stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0; stk_raddr = '0;
    alu_op = c8ic_pkg::ALU_ADD12; alu_a = '0; alu_b = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      c8ic_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_data;
          rs_status_nxt = c8ic_pkg::STAT_OK;
          rs_rbyte_nxt = '0;
          rs_row_nxt = '0;
          state_nxt = c8ic_pkg::S_CMD;
        end
      end
      c8ic_pkg::S_CMD: begin
        state_nxt = c8ic_pkg::S_DONE;
        unique case (cmd_r.cmd)
          c8ic_pkg::CMD_WRITE: begin
            pm_we = 1'b1;
            pm_waddr = cmd_r.address;
            pm_wdata = cmd_r.write_data;
          end
          c8ic_pkg::CMD_EXEC: begin
            pm_raddr = pc_r;
            state_nxt = c8ic_pkg::S_F1;
          end
          c8ic_pkg::CMD_TICK: begin
            if (dly_r != 8'd0) dly_nxt = dly_r - 8'd1;
          end
          c8ic_pkg::CMD_KEY: begin
            if (cmd_r.key_pressed) begin
              keys_nxt = keys_r | (16'd1 << cmd_r.key_number);
            end else begin
              keys_nxt = keys_r & ~(16'd1 << cmd_r.key_number);
              if (phase_r == c8ic_pkg::PHASE_WAIT) begin
                capk_nxt = cmd_r.key_number;
                phase_nxt = c8ic_pkg::PHASE_GOT;
              end
            end
          end
          c8ic_pkg::CMD_READ: begin
            pm_raddr = cmd_r.address;
            state_nxt = c8ic_pkg::S_RDB;
          end
          c8ic_pkg::CMD_ROW: begin
            dp_raddr = cmd_r.display_row;
            state_nxt = c8ic_pkg::S_RDROW;
          end
          default: state_nxt = c8ic_pkg::S_DONE;
        endcase
      end
      c8ic_pkg::S_RDB: begin
        rs_rbyte_nxt = pm_rdata;
        state_nxt = c8ic_pkg::S_DONE;
      end
      c8ic_pkg::S_RDROW: begin
        rs_row_nxt = dp_val;
        state_nxt = c8ic_pkg::S_DONE;
      end
      c8ic_pkg::S_F1: begin
        hi_nxt = pm_rdata;
        pm_raddr = pc_r + 12'd1;
        state_nxt = c8ic_pkg::S_F2;
      end
      c8ic_pkg::S_F2: begin
        lo_nxt = pm_rdata;
        alu_a = pc_r;
        alu_b = 12'd2;
        pc_nxt = alu_y;
        rf_raddr = x;
        state_nxt = c8ic_pkg::S_F3;
      end
      c8ic_pkg::S_F3: begin
        vx_nxt = rf_val;
        rf_raddr = lo_r[7:4];
        state_nxt = c8ic_pkg::S_F4;
      end
      c8ic_pkg::S_F4: begin
        vy_nxt = rf_val;
        rf_raddr = '0;
        state_nxt = c8ic_pkg::S_F5;
      end
      c8ic_pkg::S_F5: begin
        v0_nxt = rf_val;
        state_nxt = c8ic_pkg::S_EXEC;
      end
      c8ic_pkg::S_EXEC: begin
        state_nxt = c8ic_pkg::S_DONE;
        unique case (hi_r[7:4])
          4'h0: begin
            if (nnn == c8ic_pkg::OPC_CLS) begin
              dp_vld_nxt = '0;
            end else if (nnn == c8ic_pkg::OPC_RET) begin
              if (lvl_r == '0) begin
                rs_status_nxt = c8ic_pkg::STAT_RET_EMPTY;
              end else begin
                lvl_nxt = lvl_dec;
                stk_raddr = lvl_dec[SAW-1:0];
                state_nxt = c8ic_pkg::S_RET;
              end
            end else begin
              rs_status_nxt = c8ic_pkg::STAT_UNSUP;
            end
          end
          4'h1: pc_nxt = nnn;
          4'h2: begin
            if (lvl_r >= LVW'(c8ic_pkg::STACK_DEPTH)) begin
              rs_status_nxt = c8ic_pkg::STAT_STK_FULL;
            end else begin
              stk_we = 1'b1;
              stk_waddr = lvl_r[SAW-1:0];
              stk_wdata = pc_r;
              lvl_nxt = lvl_r + LVW'(1);
              pc_nxt = nnn;
            end
          end
          4'h3, 4'h4, 4'h5, 4'h9: begin
            alu_op = c8ic_pkg::ALU_XOR;
            alu_a = {4'd0, vx_r};
            alu_b = (hi_r[7:4] == 4'h3 || hi_r[7:4] == 4'h4) ? {4'd0, lo_r}
                                                              : {4'd0, vy_r};
            if ((hi_r[7:4] == 4'h3 || hi_r[7:4] == 4'h5) == alu_z) begin
              state_nxt = c8ic_pkg::S_SKIP;
            end
          end
          4'h6: begin
            rf_we = 1'b1; rf_waddr = x; rf_wdata = lo_r;
          end
          4'h7: begin
            alu_op = c8ic_pkg::ALU_ADD8;
            alu_a = {4'd0, vx_r}; alu_b = {4'd0, lo_r};
            rf_we = 1'b1; rf_waddr = x; rf_wdata = alu_y[7:0];
          end
          4'h8: begin
            alu_a = {4'd0, vx_r};
            alu_b = {4'd0, vy_r};
            unique case (lo_r[3:0])
              4'h0: begin
                rf_we = 1'b1; rf_waddr = x; rf_wdata = vy_r;
              end
              4'h1, 4'h2, 4'h3: begin
                alu_op = (lo_r[3:0] == 4'h1) ? c8ic_pkg::ALU_OR :
                         (lo_r[3:0] == 4'h2) ? c8ic_pkg::ALU_AND : c8ic_pkg::ALU_XOR;
                rf_we = 1'b1; rf_waddr = x; rf_wdata = alu_y[7:0];
              end
              4'h4, 4'h5, 4'h6, 4'h7, 4'hE: begin
                if (lo_r[3:0] == 4'h4) begin
                  alu_op = c8ic_pkg::ALU_ADD8;
                end else if (lo_r[3:0] == 4'h5) begin
                  alu_op = c8ic_pkg::ALU_SUB8;
                end else if (lo_r[3:0] == 4'h7) begin
                  alu_op = c8ic_pkg::ALU_SUB8;
                  alu_a = {4'd0, vy_r};
                  alu_b = {4'd0, vx_r};
                end else begin
                  alu_op = (lo_r[3:0] == 4'h6) ? c8ic_pkg::ALU_SHR : c8ic_pkg::ALU_SHL;
                  alu_a = shift_vy_r ? {4'd0, vy_r} : {4'd0, vx_r};
                end
                rf_we = 1'b1; rf_waddr = 4'hF; rf_wdata = {7'd0, alu_c};
                res_nxt = alu_y;
                state_nxt = c8ic_pkg::S_WRX;
              end
              default: rs_status_nxt = c8ic_pkg::STAT_UNSUP;
            endcase
          end
          4'hA: idx_nxt = nnn;
          4'hB: begin
            alu_a = nnn;
            alu_b = {4'd0, ofs_vx_r ? vx_r : v0_r};
            pc_nxt = alu_y;
          end
          4'hC: begin
            rf_we = 1'b1; rf_waddr = x; rf_wdata = cmd_r.random_byte & lo_r;
          end
          4'hD: begin
            cnt_nxt = '0;
            col_nxt = 1'b0;
            state_nxt = c8ic_pkg::S_DRRD;
          end
          4'hE: begin
            if (lo_r == c8ic_pkg::OPC_SKP) begin
              if (pressed) state_nxt = c8ic_pkg::S_SKIP;
            end else if (lo_r == c8ic_pkg::OPC_SKNP) begin
              if (!pressed) state_nxt = c8ic_pkg::S_SKIP;
            end else begin
              rs_status_nxt = c8ic_pkg::STAT_UNSUP;
            end
          end
          4'hF: begin
            unique case (lo_r)
              c8ic_pkg::OPF_GET_DLY: begin
                rf_we = 1'b1; rf_waddr = x; rf_wdata = dly_r;
              end
              c8ic_pkg::OPF_WAITKEY: begin
                if (phase_r == c8ic_pkg::PHASE_GOT) begin
                  rf_we = 1'b1; rf_waddr = x; rf_wdata = {4'd0, capk_r};
                  capk_nxt = '0;
                  phase_nxt = c8ic_pkg::PHASE_IDLE;
                end else begin
                  phase_nxt = c8ic_pkg::PHASE_WAIT;
                  alu_a = pc_r;
                  alu_b = 12'hFFE;
                  pc_nxt = alu_y;
                  rs_status_nxt = c8ic_pkg::STAT_WAIT_KEY;
                end
              end
              c8ic_pkg::OPF_SET_DLY: dly_nxt = vx_r;
              c8ic_pkg::OPF_SET_SND: state_nxt = c8ic_pkg::S_DONE;
              c8ic_pkg::OPF_ADD_I: begin
                alu_a = idx_r;
                alu_b = {4'd0, vx_r};
                idx_nxt = alu_y;
                rf_we = 1'b1; rf_waddr = 4'hF; rf_wdata = {7'd0, alu_c};
              end
              c8ic_pkg::OPF_FONT: begin
                alu_a = {6'd0, vx_r[3:0], 2'd0};
                alu_b = {8'd0, vx_r[3:0]};
                res_nxt = alu_y;
                state_nxt = c8ic_pkg::S_FONT;
              end
              c8ic_pkg::OPF_BCD: begin
                res_nxt = {4'd0, vx_r};
                hund_nxt = '0;
                tens_nxt = '0;
                state_nxt = c8ic_pkg::S_BCDH;
              end
              c8ic_pkg::OPF_STORE: begin
                cnt_nxt = '0;
                state_nxt = c8ic_pkg::S_STRD;
              end
              c8ic_pkg::OPF_LOAD: begin
                cnt_nxt = '0;
                state_nxt = c8ic_pkg::S_LDRD;
              end
              default: rs_status_nxt = c8ic_pkg::STAT_UNSUP;
            endcase
          end
          default: state_nxt = c8ic_pkg::S_DONE;
        endcase
      end
      c8ic_pkg::S_RET: begin
        pc_nxt = stk_rdata;
        state_nxt = c8ic_pkg::S_DONE;
      end
      c8ic_pkg::S_SKIP: begin
        alu_a = pc_r;
        alu_b = 12'd2;
        pc_nxt = alu_y;
        state_nxt = c8ic_pkg::S_DONE;
      end
      c8ic_pkg::S_WRX: begin
        rf_we = 1'b1; rf_waddr = x; rf_wdata = res_r[7:0];
        state_nxt = c8ic_pkg::S_DONE;
      end
      c8ic_pkg::S_FONT: begin
        alu_a = font_base_r;
        alu_b = res_r;
        idx_nxt = alu_y;
        state_nxt = c8ic_pkg::S_DONE;
      end
      c8ic_pkg::S_BCDH: begin
        alu_op = c8ic_pkg::ALU_SUB8;
        alu_a = res_r;
        alu_b = 12'd100;
        if (alu_c) begin
          res_nxt = alu_y;
          hund_nxt = hund_r + 4'd1;
        end else begin
          state_nxt = c8ic_pkg::S_BCDT;
        end
      end
      c8ic_pkg::S_BCDT: begin
        alu_op = c8ic_pkg::ALU_SUB8;
        alu_a = res_r;
        alu_b = 12'd10;
        if (alu_c) begin
          res_nxt = alu_y;
          tens_nxt = tens_r + 4'd1;
        end else begin
          state_nxt = c8ic_pkg::S_BCDW0;
        end
      end
      c8ic_pkg::S_BCDW0: begin
        pm_we = 1'b1; pm_waddr = idx_r; pm_wdata = {4'd0, hund_r};
        state_nxt = c8ic_pkg::S_BCDW1;
      end
      c8ic_pkg::S_BCDW1: begin
        pm_we = 1'b1; pm_waddr = idx_r + 12'd1; pm_wdata = {4'd0, tens_r};
        state_nxt = c8ic_pkg::S_BCDW2;
      end
      c8ic_pkg::S_BCDW2: begin
        pm_we = 1'b1; pm_waddr = idx_r + 12'd2; pm_wdata = res_r[7:0];
        state_nxt = c8ic_pkg::S_DONE;
      end
      c8ic_pkg::S_STRD: begin
        rf_raddr = cnt_r;
        state_nxt = c8ic_pkg::S_STWR;
      end
      c8ic_pkg::S_STWR: begin
        pm_we = 1'b1; pm_waddr = idx_r + {8'd0, cnt_r}; pm_wdata = rf_val;
        cnt_nxt = cnt_r + 4'd1;
        state_nxt = (cnt_r == x) ? c8ic_pkg::S_ADV : c8ic_pkg::S_STRD;
      end
      c8ic_pkg::S_LDRD: begin
        pm_raddr = idx_r + {8'd0, cnt_r};
        state_nxt = c8ic_pkg::S_LDWR;
      end
      c8ic_pkg::S_LDWR: begin
        rf_we = 1'b1; rf_waddr = cnt_r; rf_wdata = pm_rdata;
        cnt_nxt = cnt_r + 4'd1;
        state_nxt = (cnt_r == x) ? c8ic_pkg::S_ADV : c8ic_pkg::S_LDRD;
      end
      c8ic_pkg::S_ADV: begin
        alu_a = idx_r;
        alu_b = {7'd0, {1'b0, x} + 5'd1};
        if (blk_adv_r) idx_nxt = alu_y;
        state_nxt = c8ic_pkg::S_DONE;
      end
      c8ic_pkg::S_DRRD: begin
        if (cnt_r == lo_r[3:0] || py[5]) begin
          rf_we = 1'b1; rf_waddr = 4'hF; rf_wdata = {7'd0, col_r};
          state_nxt = c8ic_pkg::S_DONE;
        end else begin
          pm_raddr = idx_r + {8'd0, cnt_r};
          dp_raddr = py[RAW-1:0];
          state_nxt = c8ic_pkg::S_DRWR;
        end
      end
      c8ic_pkg::S_DRWR: begin
        if ((dp_val & mask) != '0) col_nxt = 1'b1;
        dp_we = 1'b1; dp_waddr = py[RAW-1:0]; dp_wdata = dp_val ^ mask;
        cnt_nxt = cnt_r + 4'd1;
        state_nxt = c8ic_pkg::S_DRRD;
      end
      c8ic_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.status = rs_status_r;
          out_data_nxt.program_counter = pc_r;
          out_data_nxt.read_byte = rs_rbyte_r;
          out_data_nxt.row_pixels = rs_row_r;
          state_nxt = c8ic_pkg::S_IDLE;
        end
      end
      default: state_nxt = c8ic_pkg::S_IDLE;
    endcase

    if (rf_we) rf_vld_nxt[rf_waddr] = 1'b1;
    if (dp_we) dp_vld_nxt[dp_waddr] = 1'b1;
    rf_rv_nxt = rf_vld_r[rf_raddr];
    dp_rv_nxt = dp_vld_r[dp_raddr];

    if (cfg_wr) begin
      unique case (paddr[4:2])
        c8ic_pkg::REG_SHIFT_VY:  shift_vy_nxt = pwdata[0];
        c8ic_pkg::REG_BLK_ADV:   blk_adv_nxt = pwdata[0];
        c8ic_pkg::REG_OFS_VX:    ofs_vx_nxt = pwdata[0];
        c8ic_pkg::REG_FONT_BASE: font_base_nxt = pwdata[11:0];
        c8ic_pkg::REG_PROG_STRT: begin
          prog_start_nxt = pwdata[11:0];
          pc_nxt = pwdata[11:0];
        end
        default: prog_start_nxt = prog_start_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= c8ic_pkg::S_IDLE;
      pc_r <= c8ic_pkg::PROG_START_RST;
      idx_r <= '0;
      lvl_r <= '0;
      dly_r <= '0;
      keys_r <= '0;
      phase_r <= c8ic_pkg::PHASE_IDLE;
      capk_r <= '0;
      shift_vy_r <= 1'b0;
      blk_adv_r <= 1'b0;
      ofs_vx_r <= 1'b0;
      font_base_r <= c8ic_pkg::FONT_BASE_RST;
      prog_start_r <= c8ic_pkg::PROG_START_RST;
      rf_vld_r <= '0;
      dp_vld_r <= '0;
      rf_rv_r <= 1'b0;
      dp_rv_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r <= pc_nxt;
      idx_r <= idx_nxt;
      lvl_r <= lvl_nxt;
      dly_r <= dly_nxt;
      keys_r <= keys_nxt;
      phase_r <= phase_nxt;
      capk_r <= capk_nxt;
      shift_vy_r <= shift_vy_nxt;
      blk_adv_r <= blk_adv_nxt;
      ofs_vx_r <= ofs_vx_nxt;
      font_base_r <= font_base_nxt;
      prog_start_r <= prog_start_nxt;
      rf_vld_r <= rf_vld_nxt;
      dp_vld_r <= dp_vld_nxt;
      rf_rv_r <= rf_rv_nxt;
      dp_rv_r <= dp_rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    vx_r <= vx_nxt;
    vy_r <= vy_nxt;
    v0_r <= v0_nxt;
    res_r <= res_nxt;
    cnt_r <= cnt_nxt;
    hund_r <= hund_nxt;
    tens_r <= tens_nxt;
    col_r <= col_nxt;
    rs_status_r <= rs_status_nxt;
    rs_rbyte_r <= rs_rbyte_nxt;
    rs_row_r <= rs_row_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: dv/c8_tb_pkg.sv
`timescale 1ns / 1ps
// Opcode groups, ALU selectors and spare command codes used by the testbench.
// Depends on nothing; shared by the checker and the testbench top.
package c8_tb_pkg;

  typedef enum logic [3:0] {
    GRP_SYS, GRP_JMP, GRP_CALL, GRP_SEQ_IMM, GRP_SNE_IMM, GRP_SEQ_REG, GRP_LD_IMM,
    GRP_ADD_IMM, GRP_ALU, GRP_SNE_REG, GRP_LD_I, GRP_JMP_OFS, GRP_RND, GRP_DRAW,
    GRP_KEY, GRP_MISC
  } op_group_t;

  localparam logic [3:0] AOP_MOV  = 4'h0;
  localparam logic [3:0] AOP_OR   = 4'h1;
  localparam logic [3:0] AOP_AND  = 4'h2;
  localparam logic [3:0] AOP_XOR  = 4'h3;
  localparam logic [3:0] AOP_ADD  = 4'h4;
  localparam logic [3:0] AOP_SUB  = 4'h5;
  localparam logic [3:0] AOP_SHR  = 4'h6;
  localparam logic [3:0] AOP_SUBN = 4'h7;
  localparam logic [3:0] AOP_SHL  = 4'hE;

  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

endpackage

FILE: dv/c8_checker.sv
`timescale 1ns / 1ps
// Checker for the CHIP-8 instruction core: snoops the config bus and both channels,
// predicts each result transaction and compares it. Depends on c8ic_pkg, c8_tb_pkg.
module c8_checker
  import c8ic_pkg::*;
  import c8_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          left_over
);

  logic        shift_vy, blk_adv, ofs_vx;
  logic [11:0] font_base, prog_start;
  logic [7:0]  v [16];
  logic [11:0] idx, pc;
  logic [11:0] stk [STACK_DEPTH];
  logic [4:0]  lvl;
  logic [7:0]  dly;
  logic [15:0] keys;
  logic [1:0]  wph;
  logic [3:0]  ckey;
  logic [7:0]  mem [MEMORY_BYTES];
  logic [63:0] rows [SCREEN_HEIGHT];
  out_item_t   expected_q [$];

  assign left_over = expected_q.size();

  task automatic reset_core();
    shift_vy = 1'b0; blk_adv = 1'b0; ofs_vx = 1'b0;
    font_base = FONT_BASE_RST; prog_start = PROG_START_RST;
    foreach (v[i]) v[i] = '0;
    foreach (stk[i]) stk[i] = '0;
    foreach (mem[i]) mem[i] = '0;
    foreach (rows[i]) rows[i] = '0;
    idx = '0; pc = PROG_START_RST; lvl = '0; dly = '0; keys = '0;
    wph = PHASE_IDLE; ckey = '0;
  endtask

  task automatic exec_instr(input logic [7:0] rnd, output logic [2:0] st);
    logic [7:0]  hi, lo, vx, vy, s, bits;
    logic [3:0]  x, y;
    logic [11:0] nnn;
    logic [8:0]  sum;
    logic [12:0] wide;
    logic        pressed;
    int          sx, sy, py, px;
    st = STAT_OK;
    hi = mem[pc];
    lo = mem[pc + 12'd1];
    pc = pc + 12'd2;
    x = hi[3:0]; y = lo[7:4]; nnn = {x, lo};
    vx = v[x]; vy = v[y];
    case (op_group_t'(hi[7:4]))
      GRP_SYS: begin
        if (nnn == OPC_CLS) begin
          foreach (rows[i]) rows[i] = '0;
        end else if (nnn == OPC_RET) begin
          if (lvl == 0) st = STAT_RET_EMPTY;
          else begin
            lvl = lvl - 5'd1;
            pc = stk[lvl[3:0]];
          end
        end else st = STAT_UNSUP;
      end
      GRP_JMP: pc = nnn;
      GRP_CALL: begin
        if (lvl >= STACK_DEPTH) st = STAT_STK_FULL;
        else begin
          stk[lvl[3:0]] = pc;
          lvl = lvl + 5'd1;
          pc = nnn;
        end
      end
      GRP_SEQ_IMM: if (vx == lo) pc = pc + 12'd2;
      GRP_SNE_IMM: if (vx != lo) pc = pc + 12'd2;
      GRP_SEQ_REG: if (vx == vy) pc = pc + 12'd2;
      GRP_SNE_REG: if (vx != vy) pc = pc + 12'd2;
      GRP_LD_IMM: v[x] = lo;
      GRP_ADD_IMM: v[x] = vx + lo;
      GRP_ALU: begin
        s = shift_vy ? vy : vx;
        case (lo[3:0])
          AOP_MOV: v[x] = vy;
          AOP_OR:  v[x] = vx | vy;
          AOP_AND: v[x] = vx & vy;
          AOP_XOR: v[x] = vx ^ vy;
          AOP_ADD: begin
            sum = {1'b0, vx} + {1'b0, vy};
            v[15] = {7'd0, sum[8]};
            v[x] = sum[7:0];
          end
          AOP_SUB: begin
            v[15] = {7'd0, vx >= vy};
            v[x] = vx - vy;
          end
          AOP_SUBN: begin
            v[15] = {7'd0, vy >= vx};
            v[x] = vy - vx;
          end
          AOP_SHR: begin
            v[15] = {7'd0, s[0]};
            v[x] = s >> 1;
          end
          AOP_SHL: begin
            v[15] = {7'd0, s[7]};
            v[x] = s << 1;
          end
          default: st = STAT_UNSUP;
        endcase
      end
      GRP_LD_I: idx = nnn;
      GRP_JMP_OFS: pc = nnn + {4'd0, (ofs_vx ? vx : v[0])};
      GRP_RND: v[x] = rnd & lo;
      GRP_DRAW: begin
        sx = vx[5:0]; sy = vy[4:0];
        v[15] = '0;
        for (int r = 0; r < lo[3:0]; r++) begin
          py = sy + r;
          if (py >= SCREEN_HEIGHT) break;
          bits = mem[idx + 12'(r)];
          for (int b = 0; b < 8; b++) begin
            px = sx + b;
            if (px >= SCREEN_WIDTH) break;
            if (bits[7 - b]) begin
              if (rows[py][px]) v[15] = 8'd1;
              rows[py][px] = ~rows[py][px];
            end
          end
        end
      end
      GRP_KEY: begin
        pressed = (vx < 8'd16) ? keys[vx[3:0]] : 1'b0;
        if (lo == OPC_SKP) begin
          if (pressed) pc = pc + 12'd2;
        end else if (lo == OPC_SKNP) begin
          if (!pressed) pc = pc + 12'd2;
        end else st = STAT_UNSUP;
      end
      default: begin
        case (lo)
          OPF_GET_DLY: v[x] = dly;
          OPF_WAITKEY: begin
            if (wph == PHASE_GOT) begin
              v[x] = {4'd0, ckey};
              ckey = '0;
              wph = PHASE_IDLE;
            end else begin
              wph = PHASE_WAIT;
              pc = pc - 12'd2;
              st = STAT_WAIT_KEY;
            end
          end
          OPF_SET_DLY: dly = vx;
          OPF_SET_SND: ;
          OPF_ADD_I: begin
            wide = {1'b0, idx} + {5'd0, vx};
            v[15] = {7'd0, wide[12]};
            idx = wide[11:0];
          end
          OPF_FONT: idx = font_base + 12'(vx[3:0]) * 12'd5;
          OPF_BCD: begin
            mem[idx] = vx / 8'd100;
            mem[idx + 12'd1] = (vx / 8'd10) % 8'd10;
            mem[idx + 12'd2] = vx % 8'd10;
          end
          OPF_STORE: begin
            for (int n = 0; n <= x; n++) mem[idx + 12'(n)] = v[n];
            if (blk_adv) idx = idx + 12'(x) + 12'd1;
          end
          OPF_LOAD: begin
            for (int n = 0; n <= x; n++) v[n] = mem[idx + 12'(n)];
            if (blk_adv) idx = idx + 12'(x) + 12'd1;
          end
          default: st = STAT_UNSUP;
        endcase
      end
    endcase
  endtask

  task automatic predict_result(input in_item_t d, output out_item_t r);
    logic [2:0] st;
    r = '0;
    case (d.cmd)
      CMD_WRITE: mem[d.address] = d.write_data;
      CMD_EXEC: begin
        exec_instr(d.random_byte, st);
        r.status = st;
      end
      CMD_TICK: if (dly != 0) dly = dly - 8'd1;
      CMD_KEY: begin
        if (d.key_pressed) keys[d.key_number] = 1'b1;
        else begin
          keys[d.key_number] = 1'b0;
          if (wph == PHASE_WAIT) begin
            ckey = d.key_number;
            wph = PHASE_GOT;
          end
        end
      end
      CMD_READ: r.read_byte = mem[d.address];
      CMD_ROW: r.row_pixels = rows[d.display_row];
      default: ;
    endcase
    r.program_counter = pc;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    int        bad;
    bad = 0;
    if (!rst_n) begin
      reset_core();
      expected_q.delete();
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_SHIFT_VY:  shift_vy = pwdata[0];
          REG_BLK_ADV:   blk_adv = pwdata[0];
          REG_OFS_VX:    ofs_vx = pwdata[0];
          REG_FONT_BASE: font_base = pwdata[11:0];
          REG_PROG_STRT: begin
            prog_start = pwdata[11:0];
            pc = pwdata[11:0];
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_result(in_data, e);
        expected_q.push_back(e);
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected");
          bad++;
        end else begin
          e = expected_q.pop_front();
          if (out_data.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_data.status);
            bad++;
          end
          if (out_data.program_counter !== e.program_counter) begin
            $error("program_counter: expected %h, got %h", e.program_counter,
                   out_data.program_counter);
            bad++;
          end
          if (out_data.read_byte !== e.read_byte) begin
            $error("read_byte: expected %h, got %h", e.read_byte, out_data.read_byte);
            bad++;
          end
          if (out_data.row_pixels !== e.row_pixels) begin
            $error("row_pixels: expected %h, got %h", e.row_pixels, out_data.row_pixels);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the CHIP-8 instruction core: clock, reset, config writes and
// command stimulus, verdict. Depends on c8ic_pkg, c8_tb_pkg and c8_checker.
module tb;
  import c8ic_pkg::*;
  import c8_tb_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 1750;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors, left_over;
  int          in_flight = 0;
  logic [11:0] last_pc = PROG_START_RST;
  int          idle_pct = 0, stall_pct = 0;
  logic        hold = 1'b0;
  int          sent = 0;
  int          cycles = 0;

  chip8_instruction_core u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  c8_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .errors, .left_over
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= hold ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n) in_flight <= 0;
    else in_flight <= in_flight + (in_valid && in_ready) - (out_valid && out_ready);
    if (out_valid && out_ready) last_pc <= out_data.program_counter;
    else if (psel && penable && pwrite && paddr[4:2] == REG_PROG_STRT)
      last_pc <= pwdata[11:0];
  end

  task automatic send(input in_item_t d);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  function automatic in_item_t rand_item(input logic [2:0] c);
    in_item_t d;
    d = in_item_t'({$urandom, $urandom});
    d.cmd = c;
    return d;
  endfunction

  task automatic send_cmd(input logic [2:0] c);
    send(rand_item(c));
  endtask

  task automatic send_write(input logic [11:0] a, input logic [7:0] b);
    in_item_t d;
    d = rand_item(CMD_WRITE);
    d.address = a;
    d.write_data = b;
    send(d);
  endtask

  task automatic send_key(input logic [3:0] k, input logic down);
    in_item_t d;
    d = rand_item(CMD_KEY);
    d.key_number = k;
    d.key_pressed = down;
    send(d);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  task automatic reg_write(input logic [2:0] r, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_misc();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) send_key(4'($urandom), 1'($urandom_range(0, 1)));
    else if (k < 60) send_cmd(CMD_TICK);
    else if (k < 75) send_cmd(CMD_READ);
    else if (k < 90) send_cmd(CMD_ROW);
    else if (k < 95) send_cmd($urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI);
    else send_cmd(CMD_WRITE);
  endtask

  function automatic logic [15:0] rand_instr();
    logic [15:0] w;
    logic [7:0]  f;
    w = 16'($urandom);
    case ($urandom_range(0, 8))
      0: f = OPF_GET_DLY;
      1: f = OPF_WAITKEY;
      2: f = OPF_SET_DLY;
      3: f = OPF_SET_SND;
      4: f = OPF_ADD_I;
      5: f = OPF_FONT;
      6: f = OPF_BCD;
      7: f = OPF_STORE;
      default: f = OPF_LOAD;
    endcase
    case ($urandom_range(0, 11))
      0: w = {GRP_SYS, $urandom_range(0, 1) ? OPC_CLS : OPC_RET};
      1: w = {GRP_KEY, w[11:8], $urandom_range(0, 1) ? OPC_SKP : OPC_SKNP};
      2, 3: w = {GRP_MISC, w[11:8], f};
      4: w = {GRP_ALU, w[11:4], $urandom_range(0, 1) ? AOP_SHL : 4'($urandom_range(0, 7))};
      5: w = {GRP_LD_IMM, w[11:0]};
      6: w = {GRP_DRAW, w[11:0]};
      7: w = {GRP_LD_I, w[11:0]};
      default: ;
    endcase
    return w;
  endfunction

  // write the program at the current pc, then run it, with commands mixed in when mix is set
  task automatic run_prog(input logic [15:0] prog[$], input int execs, input bit mix);
    logic [11:0] p;
    wait_idle();
    p = last_pc;
    foreach (prog[i]) begin
      send_write(p + 12'(2 * i), prog[i][15:8]);
      send_write(p + 12'(2 * i + 1), prog[i][7:0]);
    end
    for (int e = 0; e < execs; e++) begin
      if (mix && $urandom_range(0, 99) < 30) send_misc();
      send_cmd(CMD_EXEC);
    end
  endtask

  task automatic set_mode(input int m);
    case (m)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 54; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 54; end
      default: begin idle_pct = 7; stall_pct = 7; end
    endcase
  endtask

  initial begin
    logic [15:0] prog[$];
    logic [11:0] p;
    in_item_t    d;
    int          ph, base;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int a = 0; a < MEMORY_BYTES; a++) send_write(12'(a), 8'($urandom));

    d = rand_item(CMD_READ); d.address = '0; send(d);
    d = rand_item(CMD_READ); d.address = '1; send(d);
    d = rand_item(CMD_ROW); d.display_row = '0; send(d);
    d = rand_item(CMD_ROW); d.display_row = '1; send(d);
    send_cmd(CMD_SPARE_LO);
    send_cmd(CMD_SPARE_HI);
    send_cmd(CMD_TICK);
    send_key(4'hF, 1'b1);
    send_key(4'hF, 1'b0);
    prog = '{{GRP_SYS, OPC_RET}, {GRP_LD_IMM, 4'd0, 8'hFF}, {GRP_LD_IMM, 4'd1, 8'h01},
             {GRP_ALU, 4'd0, 4'd1, AOP_ADD}, {GRP_ALU, 4'd0, 4'd1, AOP_SUB},
             {GRP_LD_IMM, 4'd2, 8'hFF}, {GRP_MISC, 4'd2, OPF_BCD},
             {GRP_LD_IMM, 4'd3, 8'h3F}, {GRP_LD_IMM, 4'd4, 8'h1F},
             {GRP_DRAW, 4'd3, 4'd4, 4'hF}, {GRP_MISC, 4'd5, OPF_WAITKEY}};
    run_prog(prog, prog.size() + 1, 1'b0);
    send_key(4'h9, 1'b0);
    send_cmd(CMD_EXEC);

    // nest calls until the stack is full, then unwind past empty
    wait_idle();
    p = last_pc;
    prog = '{{GRP_CALL, p}, {GRP_SYS, OPC_RET}};
    run_prog(prog, STACK_DEPTH + 1, 1'b0);
    for (int i = 0; i <= STACK_DEPTH; i++) send_cmd(CMD_EXEC);

    base = sent;
    ph = 0;
    while (sent - base < RANDOM_ITEMS) begin
      wait_idle();
      case (ph % 4)
        0: begin
          reg_write(REG_SHIFT_VY, 1); reg_write(REG_BLK_ADV, 1); reg_write(REG_OFS_VX, 1);
          reg_write(REG_FONT_BASE, 0); reg_write(REG_PROG_STRT, 0);
        end
        1: begin
          reg_write(REG_SHIFT_VY, 0); reg_write(REG_BLK_ADV, 0); reg_write(REG_OFS_VX, 0);
          reg_write(REG_FONT_BASE, 32'hFFF); reg_write(REG_PROG_STRT, 32'hFFF);
        end
        2: begin
          reg_write(REG_SHIFT_VY, 1); reg_write(REG_BLK_ADV, 0); reg_write(REG_OFS_VX, 1);
          reg_write(REG_FONT_BASE, 32'(FONT_BASE_RST));
          reg_write(REG_PROG_STRT, 32'(PROG_START_RST));
          fork
            begin
              hold <= 1'b1;
              repeat (400) @(posedge clk);
              hold <= 1'b0;
            end
          join_none
        end
        default: begin
          reg_write(REG_SHIFT_VY, $urandom_range(0, 1));
          reg_write(REG_BLK_ADV, $urandom_range(0, 1));
          reg_write(REG_OFS_VX, $urandom_range(0, 1));
          reg_write(REG_FONT_BASE, $urandom_range(0, 4095));
          reg_write(REG_PROG_STRT, $urandom_range(0, 4095));
        end
      endcase
      set_mode(ph % 4);
      while (sent - base < RANDOM_ITEMS && sent - base < (ph + 1) * 230) begin
        prog.delete();
        repeat ($urandom_range(3, 10)) prog.push_back(rand_instr());
        run_prog(prog, prog.size() + $urandom_range(0, 4), 1'b1);
      end
      ph++;
    end

    wait_idle();
    repeat (60) @(posedge clk);
    if (errors == 0 && left_over == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
